>>> rtl/tqv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqv_pkg: shared types and constants for the TLV query validator
// Holds the MD5 round tables, protocol constants and small helper types.
// ----------------------------------------------------------------------------
package tqv_pkg;

    localparam int unsigned HdrBytes    = 22;
    localparam int unsigned MinSize     = 38;
    localparam int unsigned DigestBytes = 16;
    localparam int unsigned TimeBytes   = 8;

    localparam logic [7:0] TagUserData = 8'h04;
    localparam logic [7:0] TagDeviceId = 8'h91;
    localparam logic [7:0] TagRxTime   = 8'h92;
    localparam logic [7:0] TagTxTime   = 8'h93;
    localparam logic [7:0] TagUpdTime  = 8'h94;

    localparam logic [1:0] VerdictOk     = 2'd0;
    localparam logic [1:0] VerdictHdr    = 2'd1;
    localparam logic [1:0] VerdictReject = 2'd2;

    localparam logic [1:0] PhaseTag = 2'd0;
    localparam logic [1:0] PhaseLen = 2'd1;
    localparam logic [1:0] PhaseVal = 2'd2;

    // Sequencer states of the MD5 unit.
    typedef enum logic [1:0] {
        MD5_IDLE,
        MD5_ROUND,
        MD5_ADD
    } md5_state_t;

    // Control from the top level to the hash unit.
    typedef struct packed {
        logic        start;
        logic        clear;
    } md5_ctrl_t;

    // Expected header bytes from position 4 to 20.
    function automatic logic [7:0] hdr_expect(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'h00;
            5'd1:  v = 8'h04;
            5'd2:  v = 8'h4E;
            5'd3:  v = 8'h48;
            5'd4:  v = 8'h41;
            5'd5:  v = 8'h31;
            5'd6:  v = 8'h01;
            5'd7:  v = 8'h04;
            5'd8:  v = 8'h00;
            5'd9:  v = 8'h00;
            5'd10: v = 8'h00;
            5'd11: v = 8'h01;
            5'd12: v = 8'h02;
            5'd13: v = 8'h01;
            5'd14: v = 8'h01;
            5'd15: v = 8'h03;
            5'd16: v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] v;
        case (i)
            6'd0:  v = 32'hd76aa478; 6'd1:  v = 32'he8c7b756;
            6'd2:  v = 32'h242070db; 6'd3:  v = 32'hc1bdceee;
            6'd4:  v = 32'hf57c0faf; 6'd5:  v = 32'h4787c62a;
            6'd6:  v = 32'ha8304613; 6'd7:  v = 32'hfd469501;
            6'd8:  v = 32'h698098d8; 6'd9:  v = 32'h8b44f7af;
            6'd10: v = 32'hffff5bb1; 6'd11: v = 32'h895cd7be;
            6'd12: v = 32'h6b901122; 6'd13: v = 32'hfd987193;
            6'd14: v = 32'ha679438e; 6'd15: v = 32'h49b40821;
            6'd16: v = 32'hf61e2562; 6'd17: v = 32'hc040b340;
            6'd18: v = 32'h265e5a51; 6'd19: v = 32'he9b6c7aa;
            6'd20: v = 32'hd62f105d; 6'd21: v = 32'h02441453;
            6'd22: v = 32'hd8a1e681; 6'd23: v = 32'he7d3fbc8;
            6'd24: v = 32'h21e1cde6; 6'd25: v = 32'hc33707d6;
            6'd26: v = 32'hf4d50d87; 6'd27: v = 32'h455a14ed;
            6'd28: v = 32'ha9e3e905; 6'd29: v = 32'hfcefa3f8;
            6'd30: v = 32'h676f02d9; 6'd31: v = 32'h8d2a4c8a;
            6'd32: v = 32'hfffa3942; 6'd33: v = 32'h8771f681;
            6'd34: v = 32'h6d9d6122; 6'd35: v = 32'hfde5380c;
            6'd36: v = 32'ha4beea44; 6'd37: v = 32'h4bdecfa9;
            6'd38: v = 32'hf6bb4b60; 6'd39: v = 32'hbebfbc70;
            6'd40: v = 32'h289b7ec6; 6'd41: v = 32'heaa127fa;
            6'd42: v = 32'hd4ef3085; 6'd43: v = 32'h04881d05;
            6'd44: v = 32'hd9d4d039; 6'd45: v = 32'he6db99e5;
            6'd46: v = 32'h1fa27cf8; 6'd47: v = 32'hc4ac5665;
            6'd48: v = 32'hf4292244; 6'd49: v = 32'h432aff97;
            6'd50: v = 32'hab9423a7; 6'd51: v = 32'hfc93a039;
            6'd52: v = 32'h655b59c3; 6'd53: v = 32'h8f0ccc92;
            6'd54: v = 32'hffeff47d; 6'd55: v = 32'h85845dd1;
            6'd56: v = 32'h6fa87e4f; 6'd57: v = 32'hfe2ce6e0;
            6'd58: v = 32'ha3014314; 6'd59: v = 32'h4e0811a1;
            6'd60: v = 32'hf7537e82; 6'd61: v = 32'hbd3af235;
            6'd62: v = 32'h2ad7d2bb; 6'd63: v = 32'heb86d391;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] v;
        case ({i[5:4], i[1:0]})
            4'd0:  v = 5'd7;  4'd1:  v = 5'd12; 4'd2:  v = 5'd17; 4'd3:  v = 5'd22;
            4'd4:  v = 5'd5;  4'd5:  v = 5'd9;  4'd6:  v = 5'd14; 4'd7:  v = 5'd20;
            4'd8:  v = 5'd4;  4'd9:  v = 5'd11; 4'd10: v = 5'd16; 4'd11: v = 5'd23;
            4'd12: v = 5'd6;  4'd13: v = 5'd10; 4'd14: v = 5'd15; 4'd15: v = 5'd21;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tqv_md5.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tqv_md5: iterative MD5 compression unit
// Holds the 16-word message block and the chaining words, absorbs one byte
// per write and runs one round per cycle when a block is complete.
// ----------------------------------------------------------------------------
module tqv_md5
    import tqv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire md5_ctrl_t   ctrl,
    input  wire logic        byte_we,
    input  wire logic [5:0]  byte_idx,
    input  wire logic [7:0]  byte_data,
    output logic             busy,
    output logic [127:0]     digest
);

    md5_state_t  state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;

    logic [31:0] f, t, rot, w;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [5:0]  r;

    // Message block store; the low byte of a word overwrites it.
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            case (byte_idx[1:0])
                2'd0: blk_reg[byte_idx[5:2]] <= {24'd0, byte_data};
                2'd1: blk_reg[byte_idx[5:2]][15:8] <= byte_data;
                2'd2: blk_reg[byte_idx[5:2]][23:16] <= byte_data;
                default: blk_reg[byte_idx[5:2]][31:24] <= byte_data;
            endcase
        end
    end

    // Round function of the current round.
    always_comb
    begin
        r = rnd_reg;
        case (r[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = r[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(r * 6'd5 + 6'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(r * 6'd3 + 6'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(r * 6'd7);
            end
        endcase
        s   = md5_rot(r);
        w   = blk_reg[g];
        t   = a_reg + f + md5_k(r) + w;
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    // Sequencer next state. A clear also abandons a compression in progress.
    always_comb
    begin
        state_next = state_reg;
        if (ctrl.clear)
            state_next = MD5_IDLE;
        else
        begin
            case (state_reg)
                MD5_IDLE:  if (ctrl.start) state_next = MD5_ROUND;
                MD5_ROUND: if (rnd_reg == 6'd63) state_next = MD5_ADD;
                MD5_ADD:   state_next = MD5_IDLE;
                default:   state_next = MD5_IDLE;
            endcase
        end
    end

    always_comb
    begin
        busy = (state_reg != MD5_IDLE);
    end

    // Working and chaining registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD5_IDLE;
            rnd_reg   <= 6'd0;
            h_reg[0]  <= 32'h67452301;
            h_reg[1]  <= 32'hefcdab89;
            h_reg[2]  <= 32'h98badcfe;
            h_reg[3]  <= 32'h10325476;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.clear)
            begin
                h_reg[0] <= 32'h67452301;
                h_reg[1] <= 32'hefcdab89;
                h_reg[2] <= 32'h98badcfe;
                h_reg[3] <= 32'h10325476;
            end
            else
            begin
                case (state_reg)
                    MD5_IDLE:
                    begin
                        if (ctrl.start)
                        begin
                            a_reg <= h_reg[0]; b_reg <= h_reg[1];
                            c_reg <= h_reg[2]; d_reg <= h_reg[3];
                            rnd_reg <= 6'd0;
                        end
                    end
                    MD5_ROUND:
                    begin
                        a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                        b_reg <= b_reg + rot;
                        rnd_reg <= rnd_reg + 6'd1;
                    end
                    MD5_ADD:
                    begin
                        h_reg[0] <= h_reg[0] + a_reg;
                        h_reg[1] <= h_reg[1] + b_reg;
                        h_reg[2] <= h_reg[2] + c_reg;
                        h_reg[3] <= h_reg[3] + d_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign digest = {h_reg[3], h_reg[2], h_reg[1], h_reg[0]};

endmodule
`default_nettype wire

>>> rtl/tlv_query_validator_md5_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_query_validator_md5_top: TLV query validator with MD5 check
// Parses a query byte stream, echoes user data and issues a final verdict.
// ----------------------------------------------------------------------------
// Each query byte is taken while the round unit is idle; a byte that completes a
// 64-byte MD5 block starts the shared round unit, which runs 64 rounds and an
// add step before the next byte is taken. A final byte that fails the checks
// gives a reject verdict; otherwise MD5 padding is appended byte by byte (one
// byte per cycle while the unit is idle), then the digest is compared and the verdict presented.
// Echo and verdict requests sit in an output register; input ready is low
// while one is held.
module tlv_query_validator_md5_top
    import tqv_pkg::*;
#(
    parameter int DEVICE_ID_BYTES = 32,
    parameter int MAX_QUERY_BYTES = 32768
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  query_byte,
    input  wire logic        end_of_query,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       echo_byte,
    output logic [1:0]       verdict,
    output logic             reply_xor,
    output logic             want_device_id,
    output logic             want_rx_time,
    output logic             want_tx_time,
    output logic             want_update_time,
    output logic [7:0]       user_data_length,
    output logic [9:0]       response_length
);

    localparam logic [15:0] MaxQ = 16'(MAX_QUERY_BYTES);
    localparam logic [15:0] DevAdd = 16'(2 + DEVICE_ID_BYTES);

    typedef enum logic [1:0] {
        ST_IN,
        ST_PAD,
        ST_CMP,
        ST_OUT
    } top_state_t;

    logic [15:0] maxresp_reg;
    top_state_t  st_reg, st_next;
    logic [15:0] pos_reg;
    logic [31:0] dsize_reg;
    logic [7:0]  dig_reg [16];
    logic [1:0]  phase_reg;
    logic [7:0]  tag_reg;
    logic [7:0]  left_reg;
    logic [15:0] plan_reg;
    logic [5:0]  flags_reg;
    logic [1:0]  rn_reg;
    logic [7:0]  ulen_reg;
    logic [15:0] pcnt_reg;
    logic [15:0] blen_reg;
    logic        ov_reg;
    logic        okind_reg;
    logic [7:0]  oecho_reg;
    logic [1:0]  over_reg;
    logic [5:0]  oflags_reg;
    logic [7:0]  oulen_reg;
    logic [9:0]  olen_reg;

    md5_ctrl_t   hctl;
    logic        h_busy, h_we;
    logic [5:0]  h_idx;
    logic [7:0]  h_data;
    logic [127:0] h_dig;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, maxresp_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            maxresp_reg <= 16'd32768;
        else if (psel && penable && pwrite && paddr == 2'd0)
            maxresp_reg <= pwdata[15:0];
    end

    // Per-byte parse logic.
    logic        acc;
    logic [31:0] ds_n;
    logic        size_ok;
    logic [15:0] bend;
    logic        rej_n, nb_n, echo_n, absorb, in_body;
    logic [1:0]  phase_n;
    logic [7:0]  tag_n, left_n, ulen_n;
    logic [15:0] plan_n;
    logic [5:0]  flags_n;
    logic [5:0]  ibit;
    logic        lenok;
    logic [15:0] iadd;
    logic [16:0] psum;
    logic        final_bad;

    assign acc = in_valid && in_ready;

    always_comb
    begin
        ds_n = dsize_reg;
        case (pos_reg)
            16'd0: ds_n[7:0]   = query_byte;
            16'd1: ds_n[15:8]  = query_byte;
            16'd2: ds_n[23:16] = query_byte;
            16'd3: ds_n[31:24] = query_byte;
            default: ;
        endcase
        size_ok = (ds_n >= 32'(MinSize)) && (ds_n <= {16'd0, MaxQ});
        bend = size_ok ? 16'(ds_n - 32'(DigestBytes)) : 16'd0;
        rej_n = rn_reg[0];
        nb_n = rn_reg[1];
        flags_n = flags_reg;
        if (pos_reg == 16'd3 && !size_ok)
            rej_n = 1'b1;
        else if (pos_reg >= 16'd4 && pos_reg <= 16'd20)
        begin
            if (query_byte != hdr_expect(5'(pos_reg - 16'd4))) rej_n = 1'b1;
        end
        else if (pos_reg == 16'd21)
        begin
            if (query_byte == 8'd2) flags_n[0] = 1'b1;
            else if (query_byte != 8'd0) rej_n = 1'b1;
        end
        absorb = (pos_reg < 16'(HdrBytes)) || (size_ok && pos_reg < bend);
        in_body = size_ok && pos_reg >= 16'(HdrBytes) && pos_reg < bend && !rej_n;
        phase_n = phase_reg;
        tag_n = tag_reg;
        left_n = left_reg;
        plan_n = plan_reg;
        ulen_n = ulen_reg;
        echo_n = 1'b0;
        ibit = 6'd0;
        lenok = 1'b0;
        iadd = 16'd0;
        case (tag_reg)
            TagUserData: begin ibit = 6'h20; lenok = query_byte >= 8'd1;
                iadd = 16'd2 + {8'd0, query_byte}; end
            TagDeviceId: begin ibit = 6'h02; lenok = query_byte == 8'd0; iadd = DevAdd; end
            TagRxTime:   begin ibit = 6'h04; lenok = query_byte == 8'd0;
                iadd = 16'(2 + TimeBytes); end
            TagTxTime:   begin ibit = 6'h08; lenok = query_byte == 8'd0;
                iadd = 16'(2 + TimeBytes); end
            TagUpdTime:  begin ibit = 6'h10; lenok = query_byte == 8'd0;
                iadd = 16'(2 + TimeBytes); end
            default: ;
        endcase
        psum = {1'b0, plan_reg} + {1'b0, iadd};
        if (in_body)
        begin
            case (phase_reg)
                PhaseTag:
                begin
                    if (nb_n) rej_n = 1'b1;
                    else
                    begin
                        tag_n = query_byte;
                        phase_n = PhaseLen;
                    end
                end
                PhaseLen:
                begin
                    if ({8'd0, query_byte} > bend - pos_reg - 16'd1) rej_n = 1'b1;
                    else
                    begin
                        if (ibit != 6'd0)
                        begin
                            if ((flags_reg & ibit) != 6'd0 || !lenok
                                || psum > {1'b0, maxresp_reg})
                                nb_n = 1'b1;
                            else
                            begin
                                flags_n = flags_n | ibit;
                                plan_n = psum[15:0];
                            end
                            if (tag_reg == TagUserData && !nb_n) ulen_n = query_byte;
                        end
                        left_n = query_byte;
                        phase_n = (query_byte != 8'd0) ? PhaseVal : PhaseTag;
                    end
                end
                default:
                begin
                    echo_n = (tag_reg == TagUserData) && !nb_n;
                    left_n = left_reg - 8'd1;
                    if (left_n == 8'd0) phase_n = PhaseTag;
                end
            endcase
        end
        if (size_ok && {16'd0, pos_reg} >= ds_n) rej_n = 1'b1;
        final_bad = rej_n || !size_ok || ({16'd0, pos_reg} + 32'd1 != ds_n)
                    || phase_n != PhaseTag || maxresp_reg < 16'(MinSize);
    end

    // Digest compare over the stored trailer.
    logic dig_match;
    always_comb
    begin
        dig_match = 1'b1;
        for (int i = 0; i < 16; i++)
            if (h_dig[8*i +: 8] != dig_reg[i]) dig_match = 1'b0;
    end

    // Padding byte stream: 0x80, zeros, then the 64-bit bit length.
    logic [15:0] pidx;
    logic [5:0]  pmod;
    logic [63:0] bits;
    logic [7:0]  pbyte;
    logic        pad_last;
    always_comb
    begin
        pidx = pcnt_reg;
        pmod = pidx[5:0];
        bits = {45'd0, blen_reg, 3'd0};
        if (pidx == blen_reg) pbyte = 8'h80;
        else if (pidx - blen_reg > 16'd8 && pmod >= 6'd56) pbyte = bits[8*pmod[2:0] +: 8];
        else if (pmod >= 6'd56 && pidx != blen_reg && pidx > blen_reg + 16'd0 &&
                 (pidx - blen_reg) >= 16'd1 && !(pidx - blen_reg <= 16'd8 &&
                 ((blen_reg[5:0] + 6'd1) > 6'd56 || blen_reg[5:0] >= 6'd56)
                 && (pidx[15:6] == blen_reg[15:6])))
            pbyte = bits[8*pmod[2:0] +: 8];
        else pbyte = 8'h00;
        pad_last = (pmod == 6'd63) && (pidx != blen_reg || 1'b1) &&
                   pbyte == bits[63:56] && pidx > blen_reg &&
                   !((pidx[15:6] == blen_reg[15:6]) && blen_reg[5:0] >= 6'd56);
    end

    // Hash unit write and start.
    always_comb
    begin
        h_we = 1'b0;
        h_idx = pos_reg[5:0];
        h_data = query_byte;
        hctl.start = 1'b0;
        hctl.clear = 1'b0;
        if (st_reg == ST_IN && acc && absorb)
        begin
            h_we = 1'b1;
            hctl.start = (pos_reg[5:0] == 6'd63);
        end
        else if (st_reg == ST_PAD && !h_busy)
        begin
            h_we = 1'b1;
            h_idx = pcnt_reg[5:0];
            h_data = pbyte;
            hctl.start = (pcnt_reg[5:0] == 6'd63);
        end
        if (st_reg == ST_OUT && ov_reg && out_ready && okind_reg) hctl.clear = 1'b1;
    end

    // Main sequencer next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IN:
                if (acc && end_of_query)
                    st_next = (final_bad) ? ST_OUT : ST_PAD;
                else if (acc && echo_n)
                    st_next = ST_OUT;
            ST_PAD:  if (!h_busy && pad_last) st_next = ST_CMP;
            ST_CMP:  if (!h_busy) st_next = ST_OUT;
            ST_OUT:  if (out_ready) st_next = ST_IN;
            default: st_next = ST_IN;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready = (st_reg == ST_IN) && !h_busy;
        out_valid = ov_reg;
    end

    // Query state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IN;
            pos_reg <= '0; dsize_reg <= '0; phase_reg <= PhaseTag; tag_reg <= '0;
            left_reg <= '0; plan_reg <= 16'(MinSize); flags_reg <= '0; rn_reg <= '0;
            ulen_reg <= '0; pcnt_reg <= '0; blen_reg <= '0;
            ov_reg <= 1'b0; okind_reg <= 1'b0; oecho_reg <= '0; over_reg <= '0;
            oflags_reg <= '0; oulen_reg <= '0; olen_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                ST_IN:
                begin
                    if (acc)
                    begin
                        dsize_reg <= ds_n; phase_reg <= phase_n; tag_reg <= tag_n;
                        left_reg <= left_n; plan_reg <= plan_n; flags_reg <= flags_n;
                        rn_reg <= {nb_n, rej_n}; ulen_reg <= ulen_n;
                        if (pos_reg != 16'hFFFF) pos_reg <= pos_reg + 16'd1;
                        if (size_ok && pos_reg >= bend && {16'd0, pos_reg} < ds_n)
                            dig_reg[4'(pos_reg - bend)] <= query_byte;
                        if (end_of_query)
                        begin
                            blen_reg <= bend;
                            pcnt_reg <= bend;
                            okind_reg <= 1'b1;
                            oecho_reg <= '0;
                            ov_reg <= final_bad;
                            over_reg <= VerdictReject;
                            oflags_reg <= '0; oulen_reg <= '0; olen_reg <= '0;
                        end
                        else if (echo_n)
                        begin
                            ov_reg <= 1'b1; okind_reg <= 1'b0; oecho_reg <= query_byte;
                            over_reg <= VerdictOk; oflags_reg <= '0;
                            oulen_reg <= '0; olen_reg <= '0;
                        end
                    end
                end
                ST_PAD:
                    if (!h_busy) pcnt_reg <= pcnt_reg + 16'd1;
                ST_CMP:
                begin
                    if (!h_busy)
                    begin
                        ov_reg <= 1'b1;
                        if (!dig_match) over_reg <= VerdictReject;
                        else if (rn_reg[1])
                        begin
                            over_reg <= VerdictHdr;
                            oflags_reg <= {5'd0, flags_reg[0]};
                            olen_reg <= 10'(MinSize);
                        end
                        else
                        begin
                            over_reg <= VerdictOk;
                            oflags_reg <= flags_reg;
                            oulen_reg <= ulen_reg;
                            olen_reg <= plan_reg[9:0];
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        ov_reg <= 1'b0;
                        if (okind_reg)
                        begin
                            pos_reg <= '0; dsize_reg <= '0; phase_reg <= PhaseTag;
                            tag_reg <= '0; left_reg <= '0; plan_reg <= 16'(MinSize);
                            flags_reg <= '0; rn_reg <= '0; ulen_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    tqv_md5 u_md5 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (hctl),
        .byte_we   (h_we),
        .byte_idx  (h_idx),
        .byte_data (h_data),
        .busy      (h_busy),
        .digest    (h_dig)
    );

    assign result_kind      = okind_reg;
    assign echo_byte        = oecho_reg;
    assign verdict          = over_reg;
    assign reply_xor        = oflags_reg[0];
    assign want_device_id   = oflags_reg[1];
    assign want_rx_time     = oflags_reg[2];
    assign want_tx_time     = oflags_reg[3];
    assign want_update_time = oflags_reg[4];
    assign user_data_length = oulen_reg;
    assign response_length  = olen_reg;

    // The unit never runs while a byte is being taken.
    assert property (@(posedge clk) disable iff (!rst_n) acc |-> !h_busy)
        else $error("byte accepted while hash unit busy");
    // A held request stays until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_kind)))
        else $error("output request dropped");
    // Input is blocked while a request is held.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready while output held");

endmodule
`default_nettype wire

>>> tb/tb_tlv_query_validator_md5_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlv_query_validator_md5_top: self-checking bench for the query validator
// Builds TLV queries with their MD5 trailer, well-formed ones and broken ones,
// streams them byte by byte with random gaps and stalls, and compares every
// echo and verdict request against a predictor of the validator.
// ----------------------------------------------------------------------------
module tb_tlv_query_validator_md5_top;
    import tqv_pkg::*;

    localparam int unsigned MAX_QUERY = 32768;
    localparam int unsigned DEVICE_ID = 32;
    localparam logic [1:0]  ADDR_MAX_RESPONSE = 2'd0;

    // One result request as seen on the output side.
    typedef struct packed {
        logic       kind;
        logic [7:0] echo;
        logic [1:0] verdict;
        logic       xr;
        logic       want_dev;
        logic       want_rx;
        logic       want_tx;
        logic       want_upd;
        logic [7:0] user_len;
        logic [9:0] resp_len;
    } reply_t;

    typedef enum int {
        Q_EMPTY, Q_GOOD, Q_ALL, Q_FAULT_LAST, Q_FAULT_MID, Q_TRUNC, Q_LONE,
        Q_BAD_SIZE, Q_PAST, Q_EARLY, Q_BAD_DIG, Q_FLIP, Q_OVERLONG
    } qkind_t;

    // Predictor of the validator plus the queue of replies still owed.
    class query_scoreboard;
        int unsigned  capacity;
        int unsigned  pos;
        logic [31:0]  decl;
        int unsigned  planned;
        logic [7:0]   user_len;
        logic [1:0]   phase;
        logic [7:0]   tag;
        logic [7:0]   left;
        logic [5:0]   flags;
        bit           rejected;
        bit           nobody;
        logic [7:0]   hdr_tail[17];
        byte unsigned msg[$];
        reply_t       owed[$];
        int           errors;

        function new();
            hdr_tail = '{8'h00, 8'h04, 8'h4E, 8'h48, 8'h41, 8'h31, 8'h01, 8'h04, 8'h00,
                         8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'h01, 8'h03, 8'h01};
            capacity = 32768;
            errors = 0;
            clear_query();
        endfunction

        function void clear_query();
            pos = 0;
            decl = '0;
            planned = MinSize;
            user_len = '0;
            phase = PhaseTag;
            tag = '0;
            left = '0;
            flags = '0;
            rejected = 0;
            nobody = 0;
            msg.delete();
        endfunction

        // Plain MD5 over the first n bytes of m; byte i of the digest in [8i+:8].
        static function bit [127:0] md5_digest(input byte unsigned m[$],
                                              input int unsigned n);
            byte unsigned blk[$];
            bit [31:0]    h[4];
            bit [31:0]    w[16];
            bit [31:0]    a, b, c, d, f, t, kk;
            int unsigned  g, s;
            int unsigned  rot_tab[16];
            longint unsigned bits;
            real          x;
            bit [127:0]   dg;
            rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
            h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
            for (int i = 0; i < n; i++)
                blk.push_back(m[i]);
            blk.push_back(8'h80);
            while (blk.size() % 64 != 56)
                blk.push_back(8'h00);
            bits = longint'(n) * 8;
            for (int i = 0; i < 8; i++)
                blk.push_back(byte'(bits >> (8 * i)));
            for (int o = 0; o < blk.size(); o += 64)
            begin
                for (int j = 0; j < 16; j++)
                    w[j] = {blk[o+4*j+3], blk[o+4*j+2], blk[o+4*j+1], blk[o+4*j]};
                a = h[0]; b = h[1]; c = h[2]; d = h[3];
                for (int i = 0; i < 64; i++)
                begin
                    if (i < 16) begin f = (b & c) | (~b & d); g = i; end
                    else if (i < 32) begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
                    else if (i < 48) begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
                    else begin f = c ^ (b | ~d); g = (7*i) % 16; end
                    x = $sin(real'(i + 1));
                    if (x < 0.0)
                        x = -x;
                    kk = 32'(longint'($floor(x * 4294967296.0)));
                    s = rot_tab[(i / 16) * 4 + (i % 4)];
                    t = a + f + kk + w[g];
                    a = d; d = c; c = b;
                    b = b + ((t << s) | (t >> (32 - s)));
                end
                h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            end
            for (int i = 0; i < 16; i++)
                dg[8*i +: 8] = h[i/4][8*(i%4) +: 8];
            return dg;
        endfunction

        function void set_capacity(logic [15:0] v);
            capacity = v;
        endfunction

        // An item is taken unless repeated, of wrong length, or too big to fit.
        function void take_item(int bitn, bit len_ok, int unsigned add);
            if (flags[bitn] || !len_ok || planned + add > capacity)
                nobody = 1;
            else
            begin
                flags[bitn] = 1;
                planned += add;
            end
        endfunction

        // Advance the predictor by one accepted query byte.
        function void note_request(logic [7:0] b, logic last);
            int unsigned p, body_end;
            bit          size_ok, echo_now, bad;
            reply_t      r;
            bit [127:0]  dg;
            p = pos;
            echo_now = 0;
            if (p < 4)
                decl |= 32'(b) << (8 * p);
            size_ok = decl >= MinSize && decl <= MAX_QUERY;
            if (p == 3 && !size_ok)
                rejected = 1;
            else if (p >= 4 && p <= 20)
            begin
                if (b != hdr_tail[p-4])
                    rejected = 1;
            end
            else if (p == 21)
            begin
                if (b == 8'd2)
                    flags[0] = 1;
                else if (b != 8'd0)
                    rejected = 1;
            end
            body_end = size_ok ? decl - DigestBytes : 0;
            if (msg.size() < 65536)
                msg.push_back(b);

            // TLV walk over the body.
            if (size_ok && p >= HdrBytes && p < body_end && !rejected)
            begin
                case (phase)
                    PhaseTag:
                    begin
                        if (nobody)
                            rejected = 1;
                        else
                        begin
                            tag = b;
                            phase = PhaseLen;
                        end
                    end
                    PhaseLen:
                    begin
                        if (b > body_end - p - 1)
                            rejected = 1;
                        else
                        begin
                            case (tag)
                                TagUserData:
                                begin
                                    take_item(5, b >= 1, 2 + b);
                                    if (!nobody)
                                        user_len = b;
                                end
                                TagDeviceId: take_item(1, b == 0, 2 + DEVICE_ID);
                                TagRxTime:   take_item(2, b == 0, 2 + TimeBytes);
                                TagTxTime:   take_item(3, b == 0, 2 + TimeBytes);
                                TagUpdTime:  take_item(4, b == 0, 2 + TimeBytes);
                                default: ;
                            endcase
                            left = b;
                            phase = (b != 0) ? PhaseVal : PhaseTag;
                        end
                    end
                    default:
                    begin
                        echo_now = tag == TagUserData && !nobody;
                        left = left - 1;
                        if (left == 0)
                            phase = PhaseTag;
                    end
                endcase
            end
            if (size_ok && p >= decl)
                rejected = 1;
            if (p < 65535)
                pos = p + 1;

            r = '0;
            if (last)
            begin
                bad = rejected || !size_ok || p + 1 != decl || phase != PhaseTag ||
                      capacity < MinSize;
                if (!bad)
                begin
                    dg = md5_digest(msg, body_end);
                    for (int i = 0; i < 16; i++)
                        if (dg[8*i +: 8] != msg[body_end + i])
                            bad = 1;
                end
                r.kind = 1;
                if (bad)
                    r.verdict = VerdictReject;
                else if (nobody)
                begin
                    r.verdict = VerdictHdr;
                    r.xr = flags[0];
                    r.resp_len = MinSize;
                end
                else
                begin
                    r.verdict = VerdictOk;
                    r.xr = flags[0];
                    r.want_dev = flags[1];
                    r.want_rx = flags[2];
                    r.want_tx = flags[3];
                    r.want_upd = flags[4];
                    r.user_len = user_len;
                    r.resp_len = planned[9:0];
                end
                clear_query();
                owed.push_back(r);
            end
            else if (echo_now)
            begin
                r.echo = b;
                owed.push_back(r);
            end
        endfunction

        function void field_cmp(string name, int unsigned e, int unsigned a);
            if (e != a)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        // Compare one returned request with the oldest one owed.
        function void check_result(reply_t got);
            reply_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            e = owed.pop_front();
            field_cmp("result_kind", e.kind, got.kind);
            field_cmp("echo_byte", e.echo, got.echo);
            field_cmp("verdict", e.verdict, got.verdict);
            field_cmp("reply_xor", e.xr, got.xr);
            field_cmp("want_device_id", e.want_dev, got.want_dev);
            field_cmp("want_rx_time", e.want_rx, got.want_rx);
            field_cmp("want_tx_time", e.want_tx, got.want_tx);
            field_cmp("want_update_time", e.want_upd, got.want_upd);
            field_cmp("user_data_length", e.user_len, got.user_len);
            field_cmp("response_length", e.resp_len, got.resp_len);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [7:0]  query_byte;
    logic        end_of_query;
    logic        out_valid, out_ready;
    logic        result_kind;
    logic [7:0]  echo_byte;
    logic [1:0]  verdict;
    logic        reply_xor, want_device_id, want_rx_time, want_tx_time, want_update_time;
    logic [7:0]  user_data_length;
    logic [9:0]  response_length;

    query_scoreboard sb;
    byte unsigned    query_q[$];
    byte unsigned    body_q[$];
    int unsigned     tx_idle_pct, rx_idle_pct;
    int unsigned     hold_left;
    int unsigned     bytes_sent;

    tlv_query_validator_md5_top #(
        .DEVICE_ID_BYTES (DEVICE_ID),
        .MAX_QUERY_BYTES (MAX_QUERY)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .query_byte       (query_byte),
        .end_of_query     (end_of_query),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .echo_byte        (echo_byte),
        .verdict          (verdict),
        .reply_xor        (reply_xor),
        .want_device_id   (want_device_id),
        .want_rx_time     (want_rx_time),
        .want_tx_time     (want_tx_time),
        .want_update_time (want_update_time),
        .user_data_length (user_data_length),
        .response_length  (response_length)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({result_kind, echo_byte, verdict, reply_xor, want_device_id,
                             want_rx_time, want_tx_time, want_update_time,
                             user_data_length, response_length});
    end

    // Run limit.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic park_input();
        in_valid <= 1'b0;
        end_of_query <= 1'b0;
    endtask

    task automatic wait_drained();
        park_input();
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only issued with nothing in flight.
    task automatic cfg_write(logic [1:0] addr, logic [31:0] data);
        wait_drained();
        repeat (300) @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_MAX_RESPONSE)
            sb.set_capacity(data[15:0]);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            park_input();
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        query_byte <= b;
        end_of_query <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(b, last);
        bytes_sent++;
    endtask

    task automatic add_record(logic [7:0] tg, int unsigned len);
        body_q.push_back(tg);
        body_q.push_back(len[7:0]);
        repeat (len) body_q.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] unknown_tag();
        logic [7:0] t;
        do
            t = 8'($urandom);
        while (t == TagUserData || (t >= TagDeviceId && t <= TagUpdTime));
        return t;
    endfunction

    // Random body records, mostly well-formed, some with a wrong length.
    task automatic random_records(int unsigned nrec);
        int unsigned sel;
        repeat (nrec)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 6)
                add_record(TagUserData, $urandom_range(1, 24));
            else if (sel < 14)
                add_record(TagDeviceId + 8'((sel - 6) % 4), 0);
            else if (sel < 17)
                add_record(unknown_tag(), $urandom_range(0, 6));
            else if (sel == 17)
                add_record(TagUserData, $urandom_range(60, 255));
            else if (sel == 18)
                add_record(TagDeviceId + 8'($urandom_range(0, 3)), $urandom_range(1, 3));
            else
                add_record(TagUserData, 0);
        end
    endtask

    // Assemble one query of the given shape into query_q.
    task automatic build_query(qkind_t k);
        int unsigned sz, sel, idx;
        bit [127:0]  dg;
        logic [31:0] bad_size;
        logic [7:0]  hdr_tail[17];
        hdr_tail = '{8'h00, 8'h04, 8'h4E, 8'h48, 8'h41, 8'h31, 8'h01, 8'h04, 8'h00,
                     8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'h01, 8'h03, 8'h01};
        body_q.delete();
        query_q.delete();
        case (k)
            Q_EMPTY: ;
            Q_ALL:
            begin
                add_record(TagDeviceId, 0);
                add_record(TagRxTime, 0);
                add_record(unknown_tag(), 3);
                add_record(TagTxTime, 0);
                add_record(TagUpdTime, 0);
                add_record(TagUserData, 255);
            end
            Q_FAULT_LAST:
            begin
                random_records($urandom_range(0, 2));
                add_record(TagDeviceId, 0);
                add_record(TagDeviceId, 0);
            end
            Q_FAULT_MID:
            begin
                add_record(TagRxTime, 0);
                add_record(TagRxTime, 0);
                add_record(TagUserData, 3);
            end
            Q_TRUNC:
            begin
                random_records($urandom_range(0, 3));
                body_q.push_back(TagUserData);
                body_q.push_back(8'($urandom_range(1, 255)));
            end
            Q_LONE:
            begin
                random_records($urandom_range(0, 3));
                body_q.push_back(unknown_tag());
            end
            default: random_records($urandom_range(0, 5));
        endcase

        sz = HdrBytes + body_q.size() + DigestBytes;
        for (int i = 0; i < 4; i++)
            query_q.push_back(8'(sz >> (8 * i)));
        foreach (hdr_tail[i])
            query_q.push_back(hdr_tail[i]);
        sel = $urandom_range(0, 19);
        query_q.push_back(sel < 10 ? 8'd0 : (sel < 19 ? 8'd2 : 8'($urandom)));
        foreach (body_q[i])
            query_q.push_back(body_q[i]);
        dg = query_scoreboard::md5_digest(query_q, query_q.size());
        for (int i = 0; i < 16; i++)
            query_q.push_back(dg[8*i +: 8]);

        // Damage applied after the digest is in place.
        case (k)
            Q_BAD_SIZE:
            begin
                sel = $urandom_range(0, 4);
                bad_size = (sel == 0) ? 32'd0 : (sel == 1) ? MinSize - 1 :
                           (sel == 2) ? MAX_QUERY + 1 : (sel == 3) ? 32'hFFFF_FFFF :
                           $urandom;
                if (bad_size >= MinSize && bad_size <= MAX_QUERY)
                    bad_size = MinSize - 1;
                for (int i = 0; i < 4; i++)
                    query_q[i] = bad_size[8*i +: 8];
            end
            Q_PAST:
                repeat ($urandom_range(1, 4)) query_q.push_back(8'($urandom));
            Q_EARLY:
                query_q = query_q[0 : $urandom_range(0, query_q.size() - 2)];
            Q_BAD_DIG:
            begin
                idx = query_q.size() - 1 - $urandom_range(0, 15);
                query_q[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            Q_FLIP:
            begin
                idx = $urandom_range(0, query_q.size() - 1);
                query_q[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            Q_OVERLONG:
                repeat (65600 - query_q.size()) query_q.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic run_query(qkind_t k);
        build_query(k);
        foreach (query_q[i])
            send_byte(query_q[i], i == query_q.size() - 1);
    endtask

    function automatic qkind_t pick_kind();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 9)
            return Q_GOOD;
        else if (sel == 9)
            return Q_EMPTY;
        return qkind_t'(sel - 8);
    endfunction

    // Main sequence.
    initial
    begin
        int unsigned target;
        int unsigned nq;
        logic [15:0] caps[3];
        sb = new();
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        in_valid <= 1'b0; query_byte <= '0; end_of_query <= 1'b0;
        out_ready <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 0;
        bytes_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed queries under the reset capacity.
        for (int k = Q_EMPTY; k <= Q_FLIP; k++)
            run_query(qkind_t'(k));

        // Capacity extremes: below the minimum, one short, exactly the minimum.
        cfg_write(ADDR_MAX_RESPONSE, 32'd0);
        run_query(Q_GOOD);
        cfg_write(ADDR_MAX_RESPONSE, MinSize - 1);
        run_query(Q_EMPTY);
        cfg_write(ADDR_MAX_RESPONSE, MinSize);
        run_query(Q_EMPTY);
        run_query(Q_ALL);

        // Random phases with different idle patterns and capacities.
        caps = '{16'hFFFF, 16'd80, 16'($urandom_range(MinSize, 400))};
        target = bytes_sent;
        for (int m = 0; m < 3; m++)
        begin
            cfg_write(ADDR_MAX_RESPONSE, caps[m]);
            tx_idle_pct = (m == 0) ? 10 : (m == 1) ? 69 : 0;
            rx_idle_pct = (m == 0) ? 69 : (m == 1) ? 10 : 0;
            target += 100;
            nq = 0;
            while (bytes_sent < target)
            begin
                if (m == 0 && nq == 0)
                begin
                    // Long receiver hold-off while queries keep coming.
                    park_input();
                    @(negedge clk);
                    hold_left = 400;
                    @(posedge clk);
                end
                run_query(pick_kind());
                nq++;
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (sb.owed.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.owed.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
